FILE: design/iq_phase_difference_aoa_core_macros.svh
// assertion macros for the phase difference angle of arrival core
`ifndef IQ_PHASE_DIFFERENCE_AOA_CORE_MACROS_SVH
`define IQ_PHASE_DIFFERENCE_AOA_CORE_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define IQAOA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("iqaoa assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define IQAOA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("iqaoa assertion failed");

`endif

FILE: design/iqaoa_pkg.sv
// shared constants, widths and arctangent table for the aoa core
package iqaoa_pkg;

   localparam int unsigned MAX_SAMPLES_DEF  = 128;
   localparam int unsigned CORDIC_STEPS_DEF = 14;

   localparam int unsigned SAMPLE_W   = 8;
   localparam int unsigned REF_W      = 4;
   localparam int unsigned GAIN_W     = 16;
   localparam int unsigned PHASE_W    = 16;
   localparam int unsigned DIFF_W     = 17;
   localparam int unsigned SUM_W      = 24;
   localparam int unsigned PAIR_W     = 7;
   localparam int unsigned MEAN_W     = 17;
   localparam int unsigned AOA_W      = 19;
   localparam int unsigned PROD_W     = 34;
   localparam int unsigned MAG_W      = 20;
   localparam int unsigned ROUND_SH   = 14;
   localparam int unsigned CORDIC_W   = 20;
   localparam int unsigned ANGLE_W    = 18;
   localparam int unsigned TABLE_IDX_W = 5;
   localparam int unsigned ATAN_W     = 13;

   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 40;
   localparam int unsigned CSR_IDX_W  = 1;

   localparam logic [REF_W-1:0]  REF_COUNT_RST  = 4'd8;
   localparam logic [GAIN_W-1:0] ANGLE_GAIN_RST = 16'd5215;

   localparam logic [CSR_IDX_W-1:0] CSR_REF_COUNT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_GAIN = 1'd1;

   localparam logic signed [ANGLE_W-1:0] PHASE_PI = 18'sd25736;

   localparam logic [PROD_W-1:0] ROUND_HALF     = 34'd8192;
   localparam logic [PROD_W-1:0] ROUND_HALF_NEG = 34'd8193;
   localparam logic [MAG_W-1:0]  AOA_POS_LIMIT  = 20'd262143;
   localparam logic [MAG_W-1:0]  AOA_NEG_LIMIT  = 20'd262144;

   function automatic logic [ATAN_W-1:0] atan_entry(input logic [TABLE_IDX_W-1:0] idx);
      logic [ATAN_W-1:0] val;
      case (idx)
         5'd0:    val = 13'd6434;
         5'd1:    val = 13'd3798;
         5'd2:    val = 13'd2007;
         5'd3:    val = 13'd1019;
         5'd4:    val = 13'd511;
         5'd5:    val = 13'd256;
         5'd6:    val = 13'd128;
         5'd7:    val = 13'd64;
         5'd8:    val = 13'd32;
         5'd9:    val = 13'd16;
         5'd10:   val = 13'd8;
         5'd11:   val = 13'd4;
         5'd12:   val = 13'd2;
         5'd13:   val = 13'd1;
         5'd14:   val = 13'd1;
         default: val = 13'd0;
      endcase
      return val;
   endfunction

endpackage

FILE: design/iqaoa_cordic.sv
// iterative vectoring cordic, one micro-rotation per cycle, phase in q3.13
module iqaoa_cordic #(
   parameter int unsigned STEPS = iqaoa_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [iqaoa_pkg::SAMPLE_W-1:0]  i_sample,
   input  logic signed [iqaoa_pkg::SAMPLE_W-1:0]  q_sample,
   output logic                                   done,
   output logic signed [iqaoa_pkg::PHASE_W-1:0]   phase
);
   import iqaoa_pkg::*;

   localparam int unsigned KW = $clog2(STEPS);
   localparam logic [KW-1:0] K_LAST = KW'(STEPS - 1);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic                       zero_ff, zero_in;
   logic [KW-1:0]              k_ff, k_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in;
   logic signed [CORDIC_W-1:0] y_ff, y_in;
   logic signed [ANGLE_W-1:0]  z_ff, z_in;

   logic signed [CORDIC_W-1:0] x_shift;
   logic signed [CORDIC_W-1:0] y_shift;
   logic signed [CORDIC_W-1:0] x_init;
   logic signed [CORDIC_W-1:0] y_init;
   logic signed [ANGLE_W-1:0]  atan_val;

   // shared shifter pair, shift amount from the step counter
   assign x_shift  = x_ff >>> k_ff;
   assign y_shift  = y_ff >>> k_ff;
   assign atan_val = $signed({{(ANGLE_W-ATAN_W){1'b0}},
                              atan_entry(TABLE_IDX_W'(k_ff))});
   assign x_init   = $signed({{(CORDIC_W-SAMPLE_W-8){i_sample[SAMPLE_W-1]}}, i_sample, 8'h00});
   assign y_init   = $signed({{(CORDIC_W-SAMPLE_W-8){q_sample[SAMPLE_W-1]}}, q_sample, 8'h00});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      k_in    = k_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         k_in    = '0;
         zero_in = (i_sample == '0) && (q_sample == '0);
         if (i_sample < 0) begin
            // left half plane: turn by pi first
            x_in = -x_init;
            y_in = -y_init;
            z_in = (q_sample >= 0) ? PHASE_PI : -PHASE_PI;
         end else begin
            x_in = x_init;
            y_in = y_init;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + y_shift;
            y_in = y_ff - x_shift;
            z_in = z_ff + atan_val;
         end else begin
            x_in = x_ff - y_shift;
            y_in = y_ff + x_shift;
            z_in = z_ff - atan_val;
         end
         if (k_ff == K_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            k_in = k_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         k_ff    <= k_in;
      end
      zero_ff <= zero_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   always_comb begin
      if (zero_ff) begin
         phase = '0;
      end else if (z_ff > PHASE_PI) begin
         phase = PHASE_W'(PHASE_PI);
      end else if (z_ff < -PHASE_PI) begin
         phase = PHASE_W'(-PHASE_PI);
      end else begin
         phase = PHASE_W'(z_ff);
      end
   end

   assign done = done_ff;

endmodule

FILE: design/iqaoa_div.sv
// restoring divider, one quotient bit per cycle, truncates toward zero
module iqaoa_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [iqaoa_pkg::SUM_W-1:0]   dividend,
   input  logic        [iqaoa_pkg::PAIR_W-1:0]  divisor,
   output logic                                 done,
   output logic signed [iqaoa_pkg::SUM_W-1:0]   quotient
);
   import iqaoa_pkg::*;

   localparam int unsigned CW = $clog2(SUM_W);
   localparam logic [CW-1:0] CNT_LAST = CW'(SUM_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [PAIR_W-1:0] rem_ff, rem_in;
   logic [PAIR_W-1:0] dvs_ff, dvs_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;

   logic [PAIR_W:0]   trial;
   logic              fits;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         neg_in  = dividend[SUM_W-1];
         quo_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      end else if (busy_ff) begin
         rem_in = fits ? PAIR_W'(trial - {1'b0, dvs_ff}) : PAIR_W'(trial);
         quo_in = {quo_ff[SUM_W-2:0], fits};
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

FILE: design/iq_phase_difference_aoa_core.sv
// phase difference angle of arrival core: sequencer, accumulator and scaling
// a skipped sample is taken without the cordic; a sample in the window waits for the shared
// iterative cordic; a last sample then runs the bit-serial divider, multiply, round and
// output load, and with no pair it skips the divider
// the result word waits in an output register while new samples are accepted
// synchronous reset restores reference_count 8 and angle_gain 5215 and clears the report
module iq_phase_difference_aoa_core #(
   parameter int unsigned MAX_SAMPLES  = iqaoa_pkg::MAX_SAMPLES_DEF,
   parameter int unsigned CORDIC_STEPS = iqaoa_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [iqaoa_pkg::REQ_DATA_W-1:0]     req_tdata,  // i_sample, q_sample
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [iqaoa_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // mean_phase, aoa_value, zero pad
   output logic                                 rsp_tuser,  // no_pairs
   input  logic                                 csr_we,
   input  logic [iqaoa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [iqaoa_pkg::GAIN_W-1:0]         csr_wdata
);
   import iqaoa_pkg::*;

   localparam int unsigned POS_W = $clog2(MAX_SAMPLES + 1);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SAMPLES);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CORDIC,
      S_FINISH,
      S_DIV,
      S_MUL,
      S_ROUND,
      S_OUT
   } state_type;

   state_type                state_ff, state_in;
   logic [REF_W-1:0]         ref_count_ff, ref_count_in;
   logic [GAIN_W-1:0]        gain_ff, gain_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic signed [PHASE_W-1:0] first_ff, first_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [PAIR_W-1:0]        pairs_ff, pairs_in;
   logic                     last_ff, last_in;
   logic                     second_ff, second_in;
   logic                     nop_ff, nop_in;
   logic signed [MEAN_W-1:0] mean_ff, mean_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [MAG_W-1:0]         mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [MEAN_W-1:0] rsp_mean_ff, rsp_mean_in;
   logic signed [AOA_W-1:0]  rsp_aoa_ff, rsp_aoa_in;
   logic                     rsp_nop_ff, rsp_nop_in;

   logic signed [SAMPLE_W-1:0] i_sample;
   logic signed [SAMPLE_W-1:0] q_sample;
   logic                       accept;
   logic                       in_window;
   logic                       cordic_start;
   logic                       cordic_done;
   logic signed [PHASE_W-1:0]  phase;
   logic                       div_start;
   logic                       div_done;
   logic signed [SUM_W-1:0]    quotient;
   logic signed [DIFF_W-1:0]   diff;
   logic [PROD_W-1:0]          rounded;
   logic signed [AOA_W-1:0]    aoa;

   assign i_sample  = $signed(req_tdata[SAMPLE_W-1:0]);
   assign q_sample  = $signed(req_tdata[2*SAMPLE_W-1:SAMPLE_W]);
   assign accept    = req_tvalid && req_tready;
   assign in_window = (pos_ff < POS_MAX) && (pos_ff >= POS_W'(ref_count_ff));
   assign cordic_start = accept && in_window;
   assign div_start    = (state_ff == S_FINISH) && (pairs_ff != '0);
   assign diff      = DIFF_W'(phase) - DIFF_W'(first_ff);
   assign rounded   = prod_ff[PROD_W-1] ? (~prod_ff + ROUND_HALF_NEG) : (prod_ff + ROUND_HALF);

   iqaoa_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .start    (cordic_start),
      .i_sample (i_sample),
      .q_sample (q_sample),
      .done     (cordic_done),
      .phase    (phase)
   );

   iqaoa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (pairs_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // saturate and restore sign
   always_comb begin
      if (neg_ff) begin
         aoa = (mag_ff > AOA_NEG_LIMIT) ? -$signed(AOA_W'(AOA_NEG_LIMIT))
                                        : -$signed(AOA_W'(mag_ff));
      end else begin
         aoa = (mag_ff > AOA_POS_LIMIT) ? $signed(AOA_W'(AOA_POS_LIMIT))
                                        : $signed(AOA_W'(mag_ff));
      end
   end

   always_comb begin
      state_in     = state_ff;
      ref_count_in = ref_count_ff;
      gain_in      = gain_ff;
      pos_in       = pos_ff;
      first_in     = first_ff;
      sum_in       = sum_ff;
      pairs_in     = pairs_ff;
      last_in      = last_ff;
      second_in    = second_ff;
      nop_in       = nop_ff;
      mean_in      = mean_ff;
      prod_in      = prod_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_mean_in  = rsp_mean_ff;
      rsp_aoa_in   = rsp_aoa_ff;
      rsp_nop_in   = rsp_nop_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_REF_COUNT:  ref_count_in = csr_wdata[REF_W-1:0];
            CSR_ANGLE_GAIN: gain_in      = csr_wdata;
            default:        ref_count_in = ref_count_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               last_in   = req_tlast;
               second_in = pos_ff[0] ^ ref_count_ff[0];
               if (pos_ff < POS_MAX) begin
                  pos_in = pos_ff + 1'b1;
               end
               if (in_window) begin
                  state_in = S_CORDIC;
               end else if (req_tlast) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_CORDIC: begin
            if (cordic_done) begin
               if (second_ff) begin
                  sum_in   = sum_ff + SUM_W'(diff);
                  pairs_in = pairs_ff + 1'b1;
               end else begin
                  first_in = phase;
               end
               state_in = last_ff ? S_FINISH : S_IDLE;
            end
         end
         S_FINISH: begin
            if (pairs_ff == '0) begin
               nop_in   = 1'b1;
               mean_in  = '0;
               state_in = S_MUL;
            end else begin
               nop_in   = 1'b0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               mean_in  = MEAN_W'(quotient);
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = mean_ff * $signed({1'b0, gain_ff});
            state_in = S_ROUND;
         end
         S_ROUND: begin
            neg_in   = prod_ff[PROD_W-1];
            mag_in   = rounded[ROUND_SH +: MAG_W];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = mean_ff;
               rsp_aoa_in   = aoa;
               rsp_nop_in   = nop_ff;
               pos_in       = '0;
               first_in     = '0;
               sum_in       = '0;
               pairs_in     = '0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ref_count_ff <= REF_COUNT_RST;
         gain_ff      <= ANGLE_GAIN_RST;
         pos_ff       <= '0;
         first_ff     <= '0;
         sum_ff       <= '0;
         pairs_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ref_count_ff <= ref_count_in;
         gain_ff      <= gain_in;
         pos_ff       <= pos_in;
         first_ff     <= first_in;
         sum_ff       <= sum_in;
         pairs_ff     <= pairs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff     <= last_in;
      second_ff   <= second_in;
      nop_ff      <= nop_in;
      mean_ff     <= mean_in;
      prod_ff     <= prod_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_aoa_ff  <= rsp_aoa_in;
      rsp_nop_ff  <= rsp_nop_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-MEAN_W-AOA_W){1'b0}}, rsp_aoa_ff, rsp_mean_ff};
   assign rsp_tuser  = rsp_nop_ff;

endmodule

FILE: design/iqaoa_checker.sv
// port-level checks for the aoa core and their bind
`include "iq_phase_difference_aoa_core_macros.svh"

module iqaoa_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 req_tlast,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [iqaoa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                                 rsp_tuser
);
   import iqaoa_pkg::*;

   localparam logic signed [MEAN_W:0] MEAN_LIMIT = 18'sd51472;

   // a stalled result word holds
   `IQAOA_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // empty report gives zero values
   `IQAOA_ASSERT_NOW(a_no_pairs_zero, rsp_tvalid && rsp_tuser, rsp_tdata == '0)

   // mean stays within two pi
   `IQAOA_ASSERT_NOW(a_mean_range, rsp_tvalid, ($signed(rsp_tdata[MEAN_W-1:0]) <= MEAN_LIMIT) && ($signed(rsp_tdata[MEAN_W-1:0]) >= -MEAN_LIMIT))

   // zero mean scales to zero
   `IQAOA_ASSERT_NOW(a_zero_scale, rsp_tvalid && (rsp_tdata[MEAN_W-1:0] == '0), rsp_tdata[MEAN_W+AOA_W-1:MEAN_W] == '0)

   // closing a report always costs cycles
   `IQAOA_ASSERT_NEXT(a_last_busy, req_tvalid && req_tready && req_tlast, !req_tready)

endmodule

bind iq_phase_difference_aoa_core iqaoa_checker u_iqaoa_checker (.*);
